// ===== hdl/rlrf_pkg.sv =====
package rlrf_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 4096;
  localparam int unsigned MAX_ROWS_DEF    = 4096;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  localparam int ROW_W  = 12;
  localparam int COL_W  = 12;
  localparam int END_W  = 13;
  localparam int AREA_W = 25;
  localparam int CSUM_W = 38;
  localparam int RSUM_W = 37;
  localparam int CENT_W = 20;
  localparam int BOX_W  = 13;
  localparam int DVS_W  = AREA_W + 1;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [END_W-1:0]  end_t;
  typedef logic [AREA_W-1:0] area_t;
  typedef logic [CSUM_W-1:0] csum_t;
  typedef logic [RSUM_W-1:0] rsum_t;
  typedef logic [CENT_W-1:0] cent_t;
  typedef logic [BOX_W-1:0]  box_t;
  typedef logic [DVS_W-1:0]  dvs_t;

  typedef struct packed {
    row_t run_row;
    col_t run_col_first;
    end_t run_col_end;
    logic last_of_region;
  } run_req_t;

  typedef struct packed {
    area_t region_area;
    cent_t centroid_col;
    cent_t centroid_row;
    col_t  box_left;
    row_t  box_top;
    box_t  box_width;
    box_t  box_height;
  } result_t;

  typedef struct packed {
    area_t area;
    csum_t csum;
    rsum_t rsum;
    row_t  min_row;
    row_t  max_row;
    col_t  min_col;
    end_t  max_col_end;
  } acc_t;

  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_COL_GO,
    ST_COL,
    ST_ROW,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/rlrf_acc.sv =====
module rlrf_acc #(
  parameter int unsigned MAX_COLUMNS = rlrf_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = rlrf_pkg::MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rlrf_pkg::acc_ctl_t ctl,
  input  rlrf_pkg::run_req_t run,
  output rlrf_pkg::acc_t     acc
);

  localparam int unsigned RowLim = MAX_ROWS - 1;
  localparam int unsigned ColLim = MAX_COLUMNS - 1;
  localparam int unsigned EndLim = MAX_COLUMNS;
  localparam int AW = rlrf_pkg::AREA_W;
  localparam int CW = rlrf_pkg::CSUM_W;
  localparam int RW = rlrf_pkg::RSUM_W;
  localparam int EW = rlrf_pkg::END_W;

  rlrf_pkg::acc_t acc_r, acc_nxt;
  rlrf_pkg::row_t row;
  rlrf_pkg::col_t cb;
  rlrf_pkg::end_t ce;
  rlrf_pkg::end_t len;
  logic [EW:0]      cterm;
  logic [2*EW:0]    cprod;
  logic [2*EW-2:0]  rprod;
  logic [AW:0]      area_s;
  logic [CW:0]      csum_s;
  logic [RW:0]      rsum_s;

  // clamp coordinates, then run length and the two weighted terms
  always_comb begin
    row = (32'(run.run_row) > RowLim) ? rlrf_pkg::row_t'(RowLim) : run.run_row;
    cb  = (32'(run.run_col_first) > ColLim) ? rlrf_pkg::col_t'(ColLim) : run.run_col_first;
    ce  = (32'(run.run_col_end) > EndLim) ? rlrf_pkg::end_t'(EndLim) : run.run_col_end;
    len = (ce > {1'b0, cb}) ? (ce - {1'b0, cb}) : '0;
    // doubled center column of each pixel summed over the run
    cterm = {1'b0, ce} + {2'b00, cb} - {{EW{1'b0}}, 1'b1};
    cprod = cterm * len;
    rprod = row * len;
    area_s = {1'b0, acc_r.area} + {{(AW + 1 - EW){1'b0}}, len};
    csum_s = {1'b0, acc_r.csum} + {{(CW - 2 * EW){1'b0}}, cprod};
    rsum_s = {1'b0, acc_r.rsum} + {{(RW + 2 - 2 * EW){1'b0}}, rprod};
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '{area: '0, csum: '0, rsum: '0, min_row: '1, max_row: '0,
                  min_col: '1, max_col_end: '0};
    end else if (ctl.add) begin
      acc_nxt.area = area_s[AW] ? '1 : area_s[AW-1:0];
      acc_nxt.csum = csum_s[CW] ? '1 : csum_s[CW-1:0];
      acc_nxt.rsum = rsum_s[RW] ? '1 : rsum_s[RW-1:0];
      if (row < acc_r.min_row)     acc_nxt.min_row = row;
      if (row > acc_r.max_row)     acc_nxt.max_row = row;
      if (cb < acc_r.min_col)      acc_nxt.min_col = cb;
      if (ce > acc_r.max_col_end)  acc_nxt.max_col_end = ce;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '{area: '0, csum: '0, rsum: '0, min_row: '1, max_row: '0,
                 min_col: '1, max_col_end: '0};
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== hdl/rlrf_div.sv =====
module rlrf_div #(
  parameter int DVD_W = rlrf_pkg::CSUM_W + rlrf_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  rlrf_pkg::dvs_t      divisor,
  output rlrf_pkg::div_stat_t stat,
  output rlrf_pkg::cent_t     quot
);

  localparam int QW    = rlrf_pkg::CENT_W;
  localparam int VW    = rlrf_pkg::DVS_W;
  localparam int HW    = DVD_W - QW;
  localparam int XW    = (HW > VW) ? HW : VW;
  localparam int CNT_W = $clog2(QW + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VW-1:0]    rem_r;
  logic [QW-1:0]    low_r;
  logic [VW-1:0]    dvs_r;
  logic [QW-1:0]    q_r;
  logic [XW-1:0]    hi_ext, dvs_ext;
  logic [VW:0]      trial, diff;
  logic             ge, zero_dvs, ovf;

  always_comb begin
    hi_ext   = XW'(dividend[DVD_W-1:QW]);
    dvs_ext  = XW'(divisor);
    zero_dvs = (divisor == '0);
    // quotient needs more than QW bits: saturate
    ovf      = (hi_ext >= dvs_ext);
    trial    = {rem_r, low_r[QW-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (zero_dvs || ovf) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CNT_W'(QW);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - {{(CNT_W-1){1'b0}}, 1'b1};
        if (cnt_r == {{(CNT_W-1){1'b0}}, 1'b1}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      if (zero_dvs) begin
        q_r <= '0;
      end else if (ovf) begin
        q_r <= '1;
      end else begin
        q_r   <= '0;
        rem_r <= hi_ext[VW-1:0];
        low_r <= dividend[QW-1:0];
        dvs_r <= divisor;
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
      low_r <= {low_r[QW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

// ===== hdl/run_length_region_features_top.sv =====
// Run-length region features.
// Input channel (in_valid/in_ready/in_data): one run request per region piece,
// with row, first column, exclusive end column and a last-of-region flag.
// Result channel (out_valid/out_ready/out_data): one request per finished
// region with area, centroid (FRAC_BITS fraction bits) and bounding box.
// A run is accepted in the idle step, then added in the accumulate step through
// the 14x13 product/saturating-add datapath; in_ready is low during the
// accumulate step, so the next run waits until the previous one is added.
// Last run of a region: after accumulation both centroids go through one
// shared bit-serial divider, column first, then row, one quotient bit per
// cycle (the bit loop is skipped when the area is zero or the quotient
// saturates). out_valid rises once the emit step loads the result; in_ready
// stays low until then.
// The result sits in an output register; new runs are taken while it waits.
// If the register is still full when the next region finishes, the block
// holds in its emit step until out_ready frees it.
// Reset (rst_n low, synchronous) clears the accumulators and out_valid.
module run_length_region_features_top #(
  parameter int unsigned MAX_COLUMNS = rlrf_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = rlrf_pkg::MAX_ROWS_DEF,
  parameter int unsigned FRAC_BITS   = rlrf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rlrf_pkg::run_req_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rlrf_pkg::result_t  out_data
);

  localparam int DvdW = rlrf_pkg::CSUM_W + FRAC_BITS;

  rlrf_pkg::state_t    state_r, state_nxt;
  rlrf_pkg::run_req_t  run_r;
  rlrf_pkg::acc_ctl_t  acc_ctl;
  rlrf_pkg::acc_t      acc;
  rlrf_pkg::div_stat_t div_stat;
  rlrf_pkg::cent_t     quot;
  rlrf_pkg::cent_t     cc_r, cr_r;
  rlrf_pkg::result_t   out_r, res;
  logic                out_valid_r;
  logic                div_start, sel_row, cap_col, cap_row, load;
  logic [DvdW-1:0]     dividend;
  rlrf_pkg::dvs_t      divisor;

  rlrf_acc #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .run   (run_r),
    .acc   (acc)
  );

  // col centroid divides by twice the area (column sum is doubled)
  always_comb begin
    if (sel_row) begin
      dividend = DvdW'(acc.rsum) << FRAC_BITS;
      divisor  = {1'b0, acc.area};
    end else begin
      dividend = DvdW'(acc.csum) << FRAC_BITS;
      divisor  = {acc.area, 1'b0};
    end
  end

  rlrf_div #(
    .DVD_W (DvdW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (div_stat),
    .quot     (quot)
  );

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rlrf_pkg::ST_IDLE:   if (in_valid) state_nxt = rlrf_pkg::ST_ACC;
      rlrf_pkg::ST_ACC:    state_nxt = run_r.last_of_region ? rlrf_pkg::ST_COL_GO
                                                            : rlrf_pkg::ST_IDLE;
      rlrf_pkg::ST_COL_GO: state_nxt = rlrf_pkg::ST_COL;
      rlrf_pkg::ST_COL:    if (div_stat.done) state_nxt = rlrf_pkg::ST_ROW;
      rlrf_pkg::ST_ROW:    if (div_stat.done) state_nxt = rlrf_pkg::ST_EMIT;
      rlrf_pkg::ST_EMIT:   if (!out_valid_r || out_ready) state_nxt = rlrf_pkg::ST_IDLE;
      default:             state_nxt = rlrf_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready      = 1'b0;
    acc_ctl.add   = 1'b0;
    acc_ctl.clear = 1'b0;
    div_start     = 1'b0;
    sel_row       = 1'b0;
    cap_col       = 1'b0;
    cap_row       = 1'b0;
    load          = 1'b0;
    case (state_r)
      rlrf_pkg::ST_IDLE:   in_ready = 1'b1;
      rlrf_pkg::ST_ACC:    acc_ctl.add = 1'b1;
      rlrf_pkg::ST_COL_GO: div_start = 1'b1;
      rlrf_pkg::ST_COL: begin
        // row division starts the cycle the column quotient lands
        sel_row   = 1'b1;
        cap_col   = div_stat.done;
        div_start = div_stat.done;
      end
      rlrf_pkg::ST_ROW:    cap_row = div_stat.done;
      rlrf_pkg::ST_EMIT: begin
        load          = !out_valid_r || out_ready;
        acc_ctl.clear = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.region_area  = acc.area;
    res.centroid_col = cc_r;
    res.centroid_row = cr_r;
    res.box_left     = acc.min_col;
    res.box_top      = acc.min_row;
    res.box_width    = (acc.max_col_end > {1'b0, acc.min_col})
                       ? (acc.max_col_end - {1'b0, acc.min_col}) : '0;
    res.box_height   = (acc.max_row >= acc.min_row)
                       ? ({1'b0, acc.max_row} - {1'b0, acc.min_row} + 13'd1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlrf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) run_r <= in_data;
    if (cap_col)              cc_r  <= quot;
    if (cap_row)              cr_r  <= quot;
    if (load)                 out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_clear_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc_ctl.clear |=> state_r == rlrf_pkg::ST_IDLE)
    else $error("accumulator clear not followed by idle");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rlrf_pkg::ST_EMIT))
    else $error("result raised outside emit step");

endmodule

// ===== sim/tb_run_length_region_features_top.sv =====
`timescale 1ns / 1ps

module tb_run_length_region_features_top;
  import rlrf_pkg::*;

  // Stimulus shape
  localparam int PLAN_RUNS   = 550;
  localparam int IDLE_PCT    = 28;
  // No idling on either side while this many runs have been accepted
  localparam int CALM_FROM   = 200;
  localparam int CALM_TO     = 320;
  // Long result hold-off, started once after this many runs
  localparam int HOLD_AT     = 100;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_AT    = 400;
  localparam int TAIL_CYCLES = 100;

  // Saturation limits of the accumulators and the centroid fields
  localparam longint unsigned AREA_LIM = (64'd1 << AREA_W) - 1;
  localparam longint unsigned CSUM_LIM = (64'd1 << CSUM_W) - 1;
  localparam longint unsigned RSUM_LIM = (64'd1 << RSUM_W) - 1;
  localparam longint unsigned CENT_LIM = (64'd1 << CENT_W) - 1;

  typedef struct {
    run_req_t req;
    bit       drain_first;  // hold this run back until no region is outstanding
  } planned_run_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  run_req_t in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  result_t  out_data;

  run_length_region_features_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Runs waiting to be offered, and region results predicted but not yet seen
  planned_run_t run_plan[$];
  result_t      pending_regions[$];
  int           plan_total;
  int           runs_accepted = 0;
  int           error_count = 0;
  bit           in_taken = 1'b0;
  logic         calm_stretch;

  assign calm_stretch = (runs_accepted >= CALM_FROM) && (runs_accepted < CALM_TO);

  // Running region state, mirrors the block's accumulators
  area_t area_total = '0;
  csum_t col_sum_x2 = '0;
  rsum_t row_total  = '0;
  row_t  row_lo     = '1;
  row_t  row_hi     = '0;
  col_t  col_lo     = '1;
  end_t  end_hi     = '0;

  // Fold one accepted run into the region; on the last run, queue the
  // region's features and start a fresh region.
  task automatic accumulate_run(input run_req_t run);
    longint unsigned row, first, stop, len, sum, cc, cr;
    result_t res;
    row   = run.run_row;
    first = run.run_col_first;
    stop  = run.run_col_end;
    if (row > MAX_ROWS_DEF - 1) row = MAX_ROWS_DEF - 1;
    if (first > MAX_COLUMNS_DEF - 1) first = MAX_COLUMNS_DEF - 1;
    if (stop > MAX_COLUMNS_DEF) stop = MAX_COLUMNS_DEF;
    len = (stop > first) ? stop - first : 0;

    // empty/inverted runs skip the sums but still move the box
    if (len > 0) begin
      sum = longint'(area_total) + len;
      area_total = (sum > AREA_LIM) ? AREA_LIM : sum;
      // doubled column center times length: (end-1 + first) * len
      sum = longint'(col_sum_x2) + (stop - 1 + first) * len;
      col_sum_x2 = (sum > CSUM_LIM) ? CSUM_LIM : sum;
      sum = longint'(row_total) + row * len;
      row_total = (sum > RSUM_LIM) ? RSUM_LIM : sum;
    end
    if (row < row_lo) row_lo = row;
    if (row > row_hi) row_hi = row;
    if (first < col_lo) col_lo = first;
    if (stop > end_hi) end_hi = stop;

    if (run.last_of_region) begin
      cc = 0;
      cr = 0;
      if (area_total != 0) begin
        cc = (longint'(col_sum_x2) << FRAC_BITS_DEF) / (2 * longint'(area_total));
        cr = (longint'(row_total) << FRAC_BITS_DEF) / longint'(area_total);
      end
      res.region_area  = area_total;
      res.centroid_col = (cc > CENT_LIM) ? CENT_LIM : cc;
      res.centroid_row = (cr > CENT_LIM) ? CENT_LIM : cr;
      res.box_left     = col_lo;
      res.box_top      = row_lo;
      res.box_width    = (end_hi > col_lo) ? longint'(end_hi) - longint'(col_lo) : 0;
      res.box_height   = (row_hi >= row_lo) ? longint'(row_hi) - longint'(row_lo) + 1 : 0;
      pending_regions.push_back(res);
      area_total = '0;
      col_sum_x2 = '0;
      row_total  = '0;
      row_lo     = '1;
      row_hi     = '0;
      col_lo     = '1;
      end_hi     = '0;
    end
  endtask

  function automatic bit field_agrees(string field, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void plan_run(int unsigned row, int unsigned first,
                                   int unsigned stop, bit last, bit drain = 1'b0);
    planned_run_t p;
    p.req.run_row        = row;
    p.req.run_col_first  = first;
    p.req.run_col_end    = stop;
    p.req.last_of_region = last;
    p.drain_first        = drain;
    run_plan.push_back(p);
  endfunction

  // Sender: a new run goes out at the falling edge once the previous one
  // was taken. Random gaps, except inside the calm stretch; a run marked
  // drain_first waits until every predicted region has come out.
  always @(negedge clk) begin : send_runs
    planned_run_t upcoming;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (run_plan.size() == 0 ||
          (run_plan[0].drain_first && pending_regions.size() != 0) ||
          (!calm_stretch && $urandom_range(99) < IDLE_PCT)) begin
        in_valid <= 1'b0;
      end else begin
        upcoming = run_plan.pop_front();
        in_data  <= upcoming.req;
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the output register
  // fills, the block parks in its emit step and backs up into in_ready.
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && runs_accepted >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Both handshakes are sampled at the rising edge.
  always @(posedge clk) begin : watch_channels
    result_t want;
    bit      ok;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      accumulate_run(in_data);
      runs_accepted <= runs_accepted + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_regions.size() == 0) begin
        $display("%0t: unexpected region result, expected none, got %p", $time, out_data);
        error_count++;
      end else begin
        want = pending_regions.pop_front();
        ok = field_agrees("region_area", want.region_area, out_data.region_area);
        ok = field_agrees("centroid_col", want.centroid_col, out_data.centroid_col) & ok;
        ok = field_agrees("centroid_row", want.centroid_row, out_data.centroid_row) & ok;
        ok = field_agrees("box_left", want.box_left, out_data.box_left) & ok;
        ok = field_agrees("box_top", want.box_top, out_data.box_top) & ok;
        ok = field_agrees("box_width", want.box_width, out_data.box_width) & ok;
        ok = field_agrees("box_height", want.box_height, out_data.box_height) & ok;
        if (!ok) error_count++;
      end
    end
  end

  initial begin
    int  shape, count, pick, size;
    int  row_at, col_at, row, first, stop;
    bit  drain, mid_drain_done;

    // Directed: coordinate extremes
    plan_run(0, 0, 4096, 1);            // full-width row at origin
    plan_run(4095, 4095, 4096, 1);      // bottom-right pixel
    plan_run(0, 0, 1, 1);               // single pixel at origin
    // empty run alone: zero area, centroids zero
    plan_run(10, 5, 5, 1);
    plan_run(7, 0, 0, 1);
    // inverted run: end left of first, box width floors at zero
    plan_run(20, 100, 50, 1);
    // end column past the image edge gets clamped
    plan_run(30, 4000, 8191, 1);
    plan_run(4095, 0, 4097, 1);
    // multi-row region ending on an empty run
    plan_run(100, 10, 20, 0);
    plan_run(101, 8, 30, 0);
    plan_run(102, 12, 18, 0);
    plan_run(103, 50, 50, 1);
    // two runs, none with pixels
    plan_run(200, 300, 300, 0);
    plan_run(205, 400, 10, 1);
    // tallest and widest box
    plan_run(0, 0, 4096, 0);
    plan_run(4095, 0, 4096, 1);
    plan_run(50, 4095, 4096, 0);
    plan_run(60, 0, 1, 1);
    // alternating bit patterns
    plan_run(2730, 1365, 2730, 0);
    plan_run(1365, 2730, 5461, 1);

    // Random regions: mostly well-formed runs on consecutive rows with
    // short lengths, some long ones, plus noise runs and empty regions.
    drain = 1'b1;
    mid_drain_done = 1'b0;
    while (run_plan.size() < PLAN_RUNS) begin
      shape  = $urandom_range(99);
      count  = (shape < 8) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      row_at = $urandom_range(0, 4095);
      col_at = $urandom_range(0, 4095);
      for (int k = 0; k < count; k++) begin
        pick = $urandom_range(99);
        if (shape >= 95) begin
          // zero-area region: every run empty or inverted
          row   = $urandom_range(0, 4095);
          first = $urandom_range(0, 4095);
          stop  = $urandom_range(0, first);
        end else if (pick < 12) begin
          row   = $urandom_range(0, 4095);
          first = $urandom_range(0, 4095);
          stop  = $urandom_range(0, 8191);
        end else begin
          row   = (row_at + k > 4095) ? 4095 : row_at + k;
          first = (col_at + $urandom_range(0, 31)) % 4096;
          size  = (pick < 80) ? $urandom_range(1, 32) :
                  (pick < 94) ? $urandom_range(33, 512) : $urandom_range(513, 4096);
          stop  = (first + size > 4096) ? 4096 : first + size;
        end
        plan_run(row, first, stop, k == count - 1, drain);
        drain = 1'b0;
      end
      if (!mid_drain_done && run_plan.size() >= DRAIN_AT) begin
        drain = 1'b1;
        mid_drain_done = 1'b1;
      end
    end
    plan_total = run_plan.size();

    wait (runs_accepted == plan_total);
    wait (pending_regions.size() == 0);
    // let any stray result show up before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_regions.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d regions still outstanding", $time, pending_regions.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
